[src/upd_pkg.sv]
// upd_pkg: shared types and character constants for the url percent decoder
// no dependencies; used by upd_step and url_percent_decoder_top

package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DIG_2   = 8'h32;
    localparam logic [7:0] CH_DIG_5   = 8'h35;

    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_PCT   = 2'd1;
    localparam logic [1:0] HELD_DIGIT = 2'd2;

    typedef logic [7:0] t_byte;

    // decoded result of one input byte: up to three words plus the next held state
    typedef struct packed {
        t_byte [2:0] words;
        logic  [1:0] count;
        logic  [1:0] held_count;
        t_byte       held_digit;
    } t_step;

    typedef struct packed {
        logic  ok;
        t_byte value;
    } t_pair;

    // listed uppercase escapes only; anything else is not ok
    function automatic t_pair decode_pair(input t_byte hi, input t_byte lo);
        t_pair r;
        r.ok    = 1'b0;
        r.value = 8'h00;
        unique case (hi)
            8'h32: begin
                if (lo >= 8'h30 && lo <= 8'h39) begin
                    r.ok    = 1'b1;
                    r.value = {4'h2, lo[3:0]};
                end else if (lo == 8'h41 || lo == 8'h42 || lo == 8'h43 || lo == 8'h46) begin
                    r.ok    = 1'b1;
                    r.value = {4'h2, lo[3:0] + 4'd9};
                end
            end
            8'h33: begin
                if (lo == 8'h41 || lo == 8'h42 || lo == 8'h44 || lo == 8'h46) begin
                    r.ok    = 1'b1;
                    r.value = {4'h3, lo[3:0] + 4'd9};
                end
            end
            8'h34: begin
                if (lo == 8'h30) begin
                    r.ok    = 1'b1;
                    r.value = 8'h40;
                end
            end
            8'h35: begin
                if (lo == 8'h42 || lo == 8'h44) begin
                    r.ok    = 1'b1;
                    r.value = {4'h5, lo[3:0] + 4'd9};
                end
            end
            default: begin
                r.ok = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

[src/upd_step.sv]
// upd_step: combinational decode of one raw byte against the held escape state
// depends on upd_pkg

module upd_step (
    input  logic [1:0]    i_held_count,
    input  upd_pkg::t_byte i_held_digit,
    input  upd_pkg::t_byte i_byte,
    input  logic          i_final,
    output upd_pkg::t_step o_step
);
    import upd_pkg::*;

    t_byte [2:0] v_words;
    logic  [1:0] v_n;
    logic  [1:0] v_hc;
    t_byte       v_hd;
    logic        v_fresh;
    t_pair       v_pair;

    always_comb begin
        v_words = '0;
        v_n     = 2'd0;
        v_hc    = HELD_NONE;
        v_hd    = i_held_digit;
        v_fresh = 1'b0;
        v_pair  = decode_pair(i_held_digit, i_byte);

        unique case (i_held_count)
            HELD_PCT: begin
                if (i_byte >= CH_DIG_2 && i_byte <= CH_DIG_5) begin
                    v_hc = HELD_DIGIT;
                    v_hd = i_byte;
                end else begin
                    v_words[v_n] = CH_PERCENT;
                    v_n          = v_n + 2'd1;
                    v_fresh      = 1'b1;
                end
            end
            HELD_DIGIT: begin
                if (v_pair.ok) begin
                    v_words[v_n] = v_pair.value;
                    v_n          = v_n + 2'd1;
                end else begin
                    v_words[v_n] = CH_PERCENT;
                    v_n          = v_n + 2'd1;
                    v_words[v_n] = i_held_digit;
                    v_n          = v_n + 2'd1;
                    v_fresh      = 1'b1;
                end
            end
            default: begin
                // nothing held (a count of three is treated the same)
                v_fresh = 1'b1;
            end
        endcase

        if (v_fresh) begin
            if (i_byte == CH_PERCENT) begin
                v_hc = HELD_PCT;
            end else begin
                v_hc = HELD_NONE;
                if (v_n != 2'd3) begin
                    v_words[v_n] = (i_byte == CH_PLUS) ? CH_SPACE : i_byte;
                    v_n          = v_n + 2'd1;
                end
            end
        end

        // end of message: flush held bytes literally
        if (i_final) begin
            if (v_hc != HELD_NONE && v_n != 2'd3) begin
                v_words[v_n] = CH_PERCENT;
                v_n          = v_n + 2'd1;
            end
            if (v_hc == HELD_DIGIT && v_n != 2'd3) begin
                v_words[v_n] = v_hd;
                v_n          = v_n + 2'd1;
            end
            v_hc = HELD_NONE;
            v_hd = 8'h00;
        end

        o_step.words      = v_words;
        o_step.count      = v_n;
        o_step.held_count = v_hc;
        o_step.held_digit = v_hd;
    end

endmodule

[src/url_percent_decoder_top.sv]
// url_percent_decoder_top: form-encoded byte stream decoder with a three-word result buffer
// depends on upd_pkg and upd_step
//
// output: a byte's first decoded word is presented in the cycle after it is accepted
// throughput: one byte per cycle while each byte yields at most one word and the
//   receiver is ready; a byte that yields n words occupies the result buffer until
//   the single output port has drained them, one word per cycle while i_ready is high
// reset: synchronous active-low i_rst_n empties the result buffer and clears the
//   held escape state; payload registers are not reset

module url_percent_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input words
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_final,
    // output words
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_message_end
);
    import upd_pkg::*;

    // held escape state: '%' alone, or '%' plus first hex digit
    logic [1:0]  r_held_count;
    t_byte       r_held_digit;

    // result buffer: word 0 is presented, higher words shift down as it drains
    t_byte [2:0] r_buf;
    logic  [1:0] r_cnt;
    logic        r_fin;

    t_step       w_step;
    logic        w_accept;
    logic        w_take;

    upd_step u_step (
        .i_held_count (r_held_count),
        .i_held_digit (r_held_digit),
        .i_byte       (i_in_byte),
        .i_final      (i_in_final),
        .o_step       (w_step)
    );

    // output side
    assign o_valid       = (r_cnt != 2'd0);
    assign o_out_byte    = r_buf[0];
    assign o_run_last    = (r_cnt == 2'd1);
    assign o_message_end = (r_cnt == 2'd1) && r_fin;

    // a new byte enters when the buffer is empty or its last word leaves this cycle
    assign o_ready  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);
    assign w_accept = i_valid && o_ready;
    assign w_take   = o_valid && i_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= 2'd0;
            r_held_count <= HELD_NONE;
            r_held_digit <= 8'h00;
        end else if (w_accept) begin
            r_cnt        <= w_step.count;
            r_held_count <= w_step.held_count;
            r_held_digit <= w_step.held_digit;
        end else if (w_take) begin
            r_cnt        <= r_cnt - 2'd1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_buf        <= w_step.words;
            r_fin        <= i_in_final;
        end else if (w_take) begin
            r_buf[0]     <= r_buf[1];
            r_buf[1]     <= r_buf[2];
        end
    end

    // a held count of three never arises
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_count != 2'd3)
        else $error("held count out of range");

    // the final byte of a message always leaves nothing held
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_final) |=> (r_held_count == HELD_NONE))
        else $error("held bytes remain after final byte");

    // draining a multi-word run without a new byte keeps the output valid
    a_run_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !w_accept && r_cnt != 2'd1) |=> o_valid)
        else $error("result run lost words");

    // a new byte never overwrites words still waiting behind the presented one
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (r_cnt == 2'd0 || (r_cnt == 2'd1 && w_take)))
        else $error("result buffer overrun");

endmodule

[test/url_percent_decoder_top_tb.sv]
`timescale 1ns / 1ps
// url_percent_decoder_top_tb: self-checking bench for the form-encoded byte decoder
// depends on upd_pkg and url_percent_decoder_top; predicts every decoded word locally

module url_percent_decoder_top_tb;
    import upd_pkg::*;

    localparam int HOLD_CYCLES = 300;   // one long receiver hold-off, fills the block
    localparam int DRAIN_CYCLES = 16;

    // one raw byte to send and one decoded word to expect
    typedef struct {
        t_byte value;
        logic  fin;
    } t_raw_word;

    typedef struct {
        t_byte value;
        logic  run_last;
        logic  msg_end;
    } t_decoded_word;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_MOSTLY} t_sink_mode;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_in_byte;
    logic       i_in_final;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_message_end;

    t_raw_word     raw_bytes_q[$];
    t_decoded_word decoded_q[$];

    // local copy of the escape state
    logic [1:0] held_cnt;
    t_byte      held_dig;

    int errors;
    int bytes_in;
    int words_checked;
    int messages;
    int gap_left;
    int burst_left;
    int sink_words;
    int sink_cycle;
    int hold_left;
    bit hold_done;
    t_sink_mode sink_mode;

    // listed escapes, two hex digits each
    string esc_tab [21] = '{"20", "21", "22", "23", "24", "25", "26", "27", "28", "29",
                            "2A", "2B", "2C", "2F", "3A", "3B", "3D", "3F", "40", "5B", "5D"};

    url_percent_decoder_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_byte     (i_in_byte),
        .i_in_final    (i_in_final),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_message_end (o_message_end)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // value of a listed uppercase escape, -1 when the pair is not listed
    function automatic int escape_value(input t_byte hi, input t_byte lo);
        int v;
        v = -1;
        if (hi == 8'h32) begin
            if (lo >= 8'h30 && lo <= 8'h39) begin
                v = int'(lo) - 'h10;                    // '0'..'9' -> 0x20..0x29
            end else if (lo == 8'h41 || lo == 8'h42 || lo == 8'h43 || lo == 8'h46) begin
                v = int'(lo) - 'h17;                    // 'A' -> 0x2a
            end
        end else if (hi == 8'h33) begin
            if (lo == 8'h41 || lo == 8'h42 || lo == 8'h44 || lo == 8'h46) begin
                v = int'(lo) - 'h07;                    // 'A' -> 0x3a
            end
        end else if (hi == 8'h34) begin
            if (lo == 8'h30) begin
                v = 'h40;
            end
        end else if (hi == 8'h35) begin
            if (lo == 8'h42 || lo == 8'h44) begin
                v = int'(lo) + 'h19;                    // 'B' -> 0x5b
            end
        end
        return v;
    endfunction

    // decode one accepted byte and queue the words it should cause
    task automatic decode_byte(input t_byte b, input logic fin);
        t_byte outs [3];
        int    n;
        int    d;
        bit    afresh;
        n = 0;
        afresh = 1'b0;
        if (held_cnt == HELD_PCT) begin
            if (b >= CH_DIG_2 && b <= CH_DIG_5) begin
                held_cnt = HELD_DIGIT;
                held_dig = b;
            end else begin
                outs[n] = CH_PERCENT;
                n = n + 1;
                afresh = 1'b1;
            end
        end else if (held_cnt == HELD_DIGIT) begin
            d = escape_value(held_dig, b);
            if (d >= 0) begin
                held_cnt = HELD_NONE;
                outs[n] = t_byte'(d);
                n = n + 1;
            end else begin
                // unknown escape: held bytes go out literally
                outs[n] = CH_PERCENT;
                outs[n + 1] = held_dig;
                n = n + 2;
                afresh = 1'b1;
            end
        end else begin
            afresh = 1'b1;
        end
        if (afresh) begin
            if (b == CH_PERCENT) begin
                held_cnt = HELD_PCT;
            end else begin
                held_cnt = HELD_NONE;
                outs[n] = (b == CH_PLUS) ? CH_SPACE : b;
                n = n + 1;
            end
        end
        // last byte flushes whatever is still held
        if (fin) begin
            if (held_cnt == HELD_PCT || held_cnt == HELD_DIGIT) begin
                outs[n] = CH_PERCENT;
                n = n + 1;
            end
            if (held_cnt == HELD_DIGIT) begin
                outs[n] = held_dig;
                n = n + 1;
            end
            held_cnt = HELD_NONE;
            held_dig = 8'h00;
        end
        for (int k = 0; k < n; k++) begin
            decoded_q.push_back('{outs[k], k == n - 1, (k == n - 1) && fin});
        end
    endtask

    task automatic push_raw(input t_byte b, input logic fin);
        raw_bytes_q.push_back('{b, fin});
        if (fin) begin
            messages = messages + 1;
        end
    endtask

    task automatic push_text(input string s, input logic fin);
        for (int i = 0; i < s.len(); i++) begin
            push_raw(t_byte'(s[i]), fin && (i == s.len() - 1));
        end
    endtask

    // sender: bursts of random length with random gaps, payload held until accepted
    always @(posedge i_clk) begin : raw_driver
        t_raw_word nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                decode_byte(i_in_byte, i_in_final);
                bytes_in = bytes_in + 1;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0 || raw_bytes_q.size() == 0) begin
                    if (gap_left > 0) begin
                        gap_left = gap_left - 1;
                    end
                    i_valid <= 1'b0;
                end else begin
                    nxt = raw_bytes_q.pop_front();
                    i_valid    <= 1'b1;
                    i_in_byte  <= nxt.value;
                    i_in_final <= nxt.fin;
                    if (burst_left > 0) begin
                        burst_left = burst_left - 1;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
            end
        end
    end

    // receiver: stall pattern redrawn at random from four modes, plus one long hold-off
    always @(posedge i_clk) begin : word_sink
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                sink_words = sink_words + 1;
            end
            sink_cycle = sink_cycle + 1;
            if (sink_cycle % 64 == 0) begin
                sink_mode = t_sink_mode'($urandom_range(0, 3));
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_ready <= 1'b0;
            end else if (!hold_done && sink_words >= 120) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_ready <= 1'b0;
            end else begin
                case (sink_mode)
                    SINK_OPEN: begin
                        i_ready <= 1'b1;
                    end
                    SINK_COIN: begin
                        i_ready <= 1'($urandom_range(0, 1));
                    end
                    SINK_SPARSE: begin
                        i_ready <= (sink_cycle % 4 == 0);
                    end
                    default: begin
                        i_ready <= ($urandom_range(0, 9) != 0);
                    end
                endcase
            end
        end
    end

    // checker: every accepted word against the oldest expectation
    always @(posedge i_clk) begin : word_checker
        t_decoded_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual out_byte=%h", $time,
                         o_out_byte);
                errors = errors + 1;
            end else begin
                want = decoded_q.pop_front();
                if (o_out_byte !== want.value) begin
                    $display("%0t: out_byte expected %h actual %h", $time, want.value,
                             o_out_byte);
                    errors = errors + 1;
                end
                if (o_run_last !== want.run_last) begin
                    $display("%0t: run_last expected %b actual %b", $time, want.run_last,
                             o_run_last);
                    errors = errors + 1;
                end
                if (o_message_end !== want.msg_end) begin
                    $display("%0t: message_end expected %b actual %b", $time, want.msg_end,
                             o_message_end);
                    errors = errors + 1;
                end
            end
            words_checked = words_checked + 1;
        end
    end

    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        string esc;
        int    r;
        int    tokens;
        int    random_start;
        t_byte lc [4];
        lc = '{8'h61, 8'h62, 8'h64, 8'h66};     // lowercase a b d f
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in_byte = 8'h00;
        i_in_final = 1'b0;
        i_ready = 1'b0;
        held_cnt = HELD_NONE;
        held_dig = 8'h00;
        errors = 0;
        bytes_in = 0;
        words_checked = 0;
        messages = 0;
        gap_left = 0;
        burst_left = 0;
        sink_words = 0;
        sink_cycle = 0;
        hold_left = 0;
        hold_done = 1'b0;
        sink_mode = SINK_OPEN;

        // directed: byte extremes, plus, decoded plus stays plus, listed escapes,
        // unknown second digit, lowercase hex, double percent, flush of three words
        push_raw(8'h00, 1'b0);
        push_raw(8'hFF, 1'b1);
        push_text("+%2B%20", 1'b1);
        push_text("%5D", 1'b0);
        push_text("%41", 1'b0);
        push_text("%2a%%g", 1'b0);
        push_text("%2%", 1'b1);

        // random messages: a mix of well-formed escapes and other random content
        random_start = raw_bytes_q.size();
        while (raw_bytes_q.size() - random_start < 450) begin
            tokens = $urandom_range(1, 10);
            for (int t = 0; t < tokens; t++) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    esc = esc_tab[$urandom_range(0, 20)];
                    push_raw(CH_PERCENT, 1'b0);
                    push_raw(t_byte'(esc[0]), 1'b0);
                    push_raw(t_byte'(esc[1]), 1'b0);
                end else if (r < 55) begin
                    push_raw(CH_PLUS, 1'b0);
                end else if (r < 75) begin
                    push_raw(t_byte'($urandom_range(0, 255)), 1'b0);
                end else if (r < 85) begin
                    // mostly broken escape: valid first digit, random second byte
                    push_raw(CH_PERCENT, 1'b0);
                    push_raw(t_byte'($urandom_range(CH_DIG_2, CH_DIG_5)), 1'b0);
                    push_raw(t_byte'($urandom_range(0, 255)), 1'b0);
                end else if (r < 92) begin
                    push_raw(CH_PERCENT, 1'b0);
                end else begin
                    push_raw(CH_PERCENT, 1'b0);
                    push_raw(t_byte'($urandom_range(CH_DIG_2, CH_DIG_5)), 1'b0);
                    push_raw(lc[$urandom_range(0, 3)], 1'b0);
                end
            end
            // last byte of the message, sometimes mid-escape
            raw_bytes_q[raw_bytes_q.size() - 1].fin = 1'b1;
            messages = messages + 1;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (raw_bytes_q.size() != 0 || i_valid || decoded_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d decoded words from %0d raw bytes in %0d messages",
                 words_checked, bytes_in, messages);
        $display("sender bursts and gaps throughout, one receiver hold-off of %0d cycles",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
src/upd_pkg.sv
src/upd_step.sv
src/url_percent_decoder_top.sv
test/url_percent_decoder_top_tb.sv
